// File: rtl/ihdp_pkg.sv
// Shared types and constants for the image header dimension parser.
package ihdp_pkg;

    localparam int unsigned HEADER_LEN = 24;
    localparam int unsigned POS_BITS   = $clog2(HEADER_LEN + 1);

    localparam logic [7:0] BYTE_FF   = 8'hFF;
    localparam logic [7:0] BYTE_SOI  = 8'hD8;
    localparam logic [7:0] BYTE_APP0 = 8'hE0;
    localparam logic [7:0] SOF_C0    = 8'hC0;
    localparam logic [7:0] SOF_C1    = 8'hC1;
    localparam logic [7:0] SOF_C2    = 8'hC2;
    localparam logic [7:0] SOF_C3    = 8'hC3;
    localparam logic [7:0] SOF_C9    = 8'hC9;
    localparam logic [7:0] SOF_CA    = 8'hCA;
    localparam logic [7:0] SOF_CB    = 8'hCB;

    localparam logic [63:0] PNG_SIGNATURE = 64'h89504E470D0A1A0A;
    localparam logic [31:0] IHDR_TAG      = 32'h49484452;
    localparam logic [31:0] JFIF_TAG      = 32'h4A464946;

    localparam logic [1:0] FMT_NONE = 2'd0;
    localparam logic [1:0] FMT_JPEG = 2'd1;
    localparam logic [1:0] FMT_PNG  = 2'd2;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_SHORT     = 2'd1;
    localparam logic [1:0] STAT_UNKNOWN   = 2'd2;
    localparam logic [1:0] STAT_TRUNCATED = 2'd3;

    typedef enum logic [3:0] {
        PH_SIG,
        PH_MARK,
        PH_CODE,
        PH_LENH,
        PH_LENL,
        PH_SKIP,
        PH_PREC,
        PH_HH,
        PH_HL,
        PH_WH,
        PH_WL,
        PH_DONE,
        PH_BAD
    } phase_t;

    typedef struct packed {
        logic        found;
        logic        bad;
        logic [15:0] width;
        logic [15:0] height;
    } walk_view_t;

    typedef struct packed {
        logic [31:0] width;
        logic [31:0] height;
        logic [1:0]  format;
        logic [1:0]  status;
    } result_t;

endpackage

// File: rtl/ihdp_seg_walker.sv
// JPEG segment walker that locates the SOF marker and captures its dimensions.
module ihdp_seg_walker
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               byte_fire,
    input  logic [7:0]         data_byte,
    input  logic               last_byte,
    input  logic               started,
    output ihdp_pkg::walk_view_t view
);

    ihdp_pkg::phase_t phase_reg;
    ihdp_pkg::phase_t phase_next;
    logic [15:0]      skip_reg;
    logic [15:0]      skip_next;
    logic [7:0]       marker_reg;
    logic [7:0]       marker_next;
    logic [15:0]      width_reg;
    logic [15:0]      width_next;
    logic [15:0]      height_reg;
    logic [15:0]      height_next;
    logic [15:0]      seg_len;

    function automatic logic is_sof(input logic [7:0] code);
        return code == ihdp_pkg::SOF_C0 || code == ihdp_pkg::SOF_C1 ||
               code == ihdp_pkg::SOF_C2 || code == ihdp_pkg::SOF_C3 ||
               code == ihdp_pkg::SOF_C9 || code == ihdp_pkg::SOF_CA ||
               code == ihdp_pkg::SOF_CB;
    endfunction

    assign seg_len = {skip_reg[15:8], data_byte};

    always_comb
    begin
        phase_next  = phase_reg;
        skip_next   = skip_reg;
        marker_next = marker_reg;
        width_next  = width_reg;
        height_next = height_reg;
        case (phase_reg)
            ihdp_pkg::PH_SIG:
            begin
                if (started)
                begin
                    phase_next = ihdp_pkg::PH_MARK;
                end
            end
            ihdp_pkg::PH_MARK:
            begin
                phase_next = (data_byte == ihdp_pkg::BYTE_FF) ? ihdp_pkg::PH_CODE
                                                              : ihdp_pkg::PH_BAD;
            end
            ihdp_pkg::PH_CODE:
            begin
                marker_next = data_byte;
                phase_next  = ihdp_pkg::PH_LENH;
            end
            ihdp_pkg::PH_LENH:
            begin
                skip_next  = {data_byte, 8'h00};
                phase_next = ihdp_pkg::PH_LENL;
            end
            ihdp_pkg::PH_LENL:
            begin
                if (is_sof(marker_reg))
                begin
                    phase_next = ihdp_pkg::PH_PREC;
                end
                else if (seg_len < 16'd2)
                begin
                    phase_next = ihdp_pkg::PH_BAD;
                end
                else if (seg_len == 16'd2)
                begin
                    phase_next = ihdp_pkg::PH_MARK;
                end
                else
                begin
                    skip_next  = seg_len - 16'd2;
                    phase_next = ihdp_pkg::PH_SKIP;
                end
            end
            ihdp_pkg::PH_SKIP:
            begin
                skip_next = skip_reg - 16'd1;
                if (skip_reg == 16'd1)
                begin
                    phase_next = ihdp_pkg::PH_MARK;
                end
            end
            ihdp_pkg::PH_PREC:
            begin
                phase_next = ihdp_pkg::PH_HH;
            end
            ihdp_pkg::PH_HH:
            begin
                height_next = {data_byte, 8'h00};
                phase_next  = ihdp_pkg::PH_HL;
            end
            ihdp_pkg::PH_HL:
            begin
                height_next = {height_reg[15:8], data_byte};
                phase_next  = ihdp_pkg::PH_WH;
            end
            ihdp_pkg::PH_WH:
            begin
                width_next = {data_byte, 8'h00};
                phase_next = ihdp_pkg::PH_WL;
            end
            ihdp_pkg::PH_WL:
            begin
                width_next = {width_reg[15:8], data_byte};
                phase_next = ihdp_pkg::PH_DONE;
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase
    end

    assign view.found  = (phase_next == ihdp_pkg::PH_DONE);
    assign view.bad    = (phase_next == ihdp_pkg::PH_BAD);
    assign view.width  = width_next;
    assign view.height = height_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= ihdp_pkg::PH_SIG;
            skip_reg   <= '0;
            marker_reg <= '0;
            width_reg  <= '0;
            height_reg <= '0;
        end
        else if (byte_fire)
        begin
            if (last_byte)
            begin
                phase_reg  <= ihdp_pkg::PH_SIG;
                skip_reg   <= '0;
                marker_reg <= '0;
                width_reg  <= '0;
                height_reg <= '0;
            end
            else
            begin
                phase_reg  <= phase_next;
                skip_reg   <= skip_next;
                marker_reg <= marker_next;
                width_reg  <= width_next;
                height_reg <= height_next;
            end
        end
    end

`ifndef SYNTHESIS
    a_skip_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == ihdp_pkg::PH_SKIP |-> skip_reg != 16'd0)
        else $error("Skip phase entered with nothing left to skip.");

    a_restart_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        byte_fire && last_byte |=> phase_reg == ihdp_pkg::PH_SIG && width_reg == 16'd0)
        else $error("Walker did not return to its start state after a final byte.");
`endif

endmodule

// File: rtl/image_header_dimension_parser.sv
// Top level of the image header dimension parser with its result register and skid stage.
// Each result is registered in the output register, or in the skid stage on a stall.
// Throughput: one byte per cycle unless stalled; each byte updates the segment walker.
// Input stalls only while a second result waits in the skid stage behind a stalled output.
// Reset (rst_n low, asynchronous) clears the parse state and empties both result stages.
// The first 24 header bytes are held without reset and are read only after being written.
module image_header_dimension_parser
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] image_width,
    output logic [31:0] image_height,
    output logic [1:0]  image_format,
    output logic [1:0]  parse_status
);

    localparam logic [ihdp_pkg::POS_BITS-1:0] POS_FULL =
        ihdp_pkg::POS_BITS'(ihdp_pkg::HEADER_LEN);
    localparam logic [ihdp_pkg::POS_BITS-1:0] POS_LAST =
        ihdp_pkg::POS_BITS'(ihdp_pkg::HEADER_LEN - 1);

    logic                          in_fire;
    logic                          res_fire;
    logic                          out_free;
    logic [ihdp_pkg::POS_BITS-1:0] pos_reg;
    logic [7:0]                    hdr_reg [ihdp_pkg::HEADER_LEN];
    logic [7:0]                    hdr_view [ihdp_pkg::HEADER_LEN];
    logic                          is_jfif;
    logic                          is_png;
    ihdp_pkg::walk_view_t          walk;
    ihdp_pkg::result_t             res;
    ihdp_pkg::result_t             out_reg;
    ihdp_pkg::result_t             skid_reg;
    logic                          out_valid_reg;
    logic                          skid_valid_reg;

    assign in_stall = skid_valid_reg;
    assign in_fire  = in_valid && !in_stall;
    assign res_fire = in_fire && last_byte;
    assign out_free = !out_valid_reg || !out_stall;

    ihdp_seg_walker u_walker
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_fire (in_fire),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .started   (pos_reg != '0),
        .view      (walk)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else if (in_fire)
        begin
            if (last_byte)
            begin
                pos_reg <= '0;
            end
            else if (pos_reg != POS_FULL)
            begin
                pos_reg <= pos_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && pos_reg != POS_FULL)
        begin
            hdr_reg[pos_reg] <= data_byte;
        end
    end

    // The last header byte may be arriving in the same transaction as the final byte.
    always_comb
    begin
        for (int i = 0; i < ihdp_pkg::HEADER_LEN; i++)
        begin
            hdr_view[i] = hdr_reg[i];
        end
        if (pos_reg == POS_LAST)
        begin
            hdr_view[ihdp_pkg::HEADER_LEN-1] = data_byte;
        end
    end

    assign is_jfif = hdr_view[0] == ihdp_pkg::BYTE_FF && hdr_view[1] == ihdp_pkg::BYTE_SOI &&
                     hdr_view[2] == ihdp_pkg::BYTE_FF && hdr_view[3] == ihdp_pkg::BYTE_APP0 &&
                     {hdr_view[6], hdr_view[7], hdr_view[8], hdr_view[9]} == ihdp_pkg::JFIF_TAG;

    assign is_png = {hdr_view[0], hdr_view[1], hdr_view[2], hdr_view[3],
                     hdr_view[4], hdr_view[5], hdr_view[6], hdr_view[7]}
                        == ihdp_pkg::PNG_SIGNATURE &&
                    {hdr_view[12], hdr_view[13], hdr_view[14], hdr_view[15]}
                        == ihdp_pkg::IHDR_TAG;

    always_comb
    begin
        res.width  = '0;
        res.height = '0;
        res.format = ihdp_pkg::FMT_NONE;
        res.status = ihdp_pkg::STAT_UNKNOWN;
        if (pos_reg < POS_LAST)
        begin
            res.status = ihdp_pkg::STAT_SHORT;
        end
        else if (is_jfif)
        begin
            if (walk.found)
            begin
                res.width  = {16'h0000, walk.width};
                res.height = {16'h0000, walk.height};
                res.format = ihdp_pkg::FMT_JPEG;
                res.status = ihdp_pkg::STAT_OK;
            end
            else if (walk.bad)
            begin
                res.status = ihdp_pkg::STAT_UNKNOWN;
            end
            else
            begin
                res.status = ihdp_pkg::STAT_TRUNCATED;
            end
        end
        else if (is_png)
        begin
            res.width  = {hdr_view[16], hdr_view[17], hdr_view[18], hdr_view[19]};
            res.height = {hdr_view[20], hdr_view[21], hdr_view[22], hdr_view[23]};
            res.format = ihdp_pkg::FMT_PNG;
            res.status = ihdp_pkg::STAT_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_free)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end
        else if (res_fire)
        begin
            if (out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else if (out_free)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_free)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (res_fire)
        begin
            if (out_free)
            begin
                out_reg <= res;
            end
            else
            begin
                skid_reg <= res;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign image_width  = out_reg.width;
    assign image_height = out_reg.height;
    assign image_format = out_reg.format;
    assign parse_status = out_reg.status;

`ifndef SYNTHESIS
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("Skid stage holds a transaction while the output register is empty.");

    a_ok_has_format: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && parse_status == ihdp_pkg::STAT_OK |-> image_format != ihdp_pkg::FMT_NONE)
        else $error("Successful result carries no format.");

    a_error_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && parse_status != ihdp_pkg::STAT_OK |->
            image_width == 32'd0 && image_height == 32'd0 &&
            image_format == ihdp_pkg::FMT_NONE)
        else $error("Error result carries nonzero dimensions or a format.");
`endif

endmodule

// File: dv/ihdp_result_checker.sv
// Checker for the image header dimension parser: tracks accepted bytes, predicts and compares results.
module ihdp_result_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [31:0] image_width,
    input  logic [31:0] image_height,
    input  logic [1:0]  image_format,
    input  logic [1:0]  parse_status,
    input  logic        end_check,
    output int          fail_count,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import ihdp_pkg::*;

    logic [31:0] byte_count;
    phase_t      walk_phase;
    logic [7:0]  header_store [HEADER_LEN];
    logic [15:0] skip_left;
    logic [7:0]  seg_code;
    logic [31:0] sof_width;
    logic [31:0] sof_height;
    logic        sof_seen;
    result_t     dims_expected [$];
    logic        leftovers_done;

    task automatic clear_parse();
        byte_count = '0;
        walk_phase = PH_SIG;
        skip_left  = '0;
        seg_code   = '0;
        sof_width  = '0;
        sof_height = '0;
        sof_seen   = 1'b0;
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        fail_count++;
        $display("MISMATCH at %0t: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    endtask

    function automatic logic is_frame_marker(input logic [7:0] m);
        return (m >= SOF_C0 && m <= SOF_C3) || (m >= SOF_C9 && m <= SOF_CB);
    endfunction

    function automatic logic [31:0] header_word(input logic [4:0] at);
        return {header_store[at], header_store[at + 5'd1], header_store[at + 5'd2],
                header_store[at + 5'd3]};
    endfunction

    task automatic absorb_byte(input logic [7:0] b, input logic fin);
        logic [31:0] prior;
        logic [15:0] seg_len;
        logic        jfif_head;
        logic        png_head;
        result_t     dims;
        prior = byte_count;
        if (prior < HEADER_LEN)
            header_store[prior[4:0]] = b;
        if (byte_count != '1)
            byte_count = byte_count + 32'd1;
        case (walk_phase)
            PH_SIG:
                if (prior >= 1)
                    walk_phase = PH_MARK;
            PH_MARK:
                walk_phase = (b == BYTE_FF) ? PH_CODE : PH_BAD;
            PH_CODE:
            begin
                seg_code   = b;
                walk_phase = PH_LENH;
            end
            PH_LENH:
            begin
                skip_left  = {b, 8'h00};
                walk_phase = PH_LENL;
            end
            PH_LENL:
            begin
                seg_len = {skip_left[15:8], b};
                if (is_frame_marker(seg_code))
                    walk_phase = PH_PREC;
                else if (seg_len < 2)
                    walk_phase = PH_BAD;
                else if (seg_len == 2)
                    walk_phase = PH_MARK;
                else
                begin
                    skip_left  = seg_len - 16'd2;
                    walk_phase = PH_SKIP;
                end
            end
            PH_SKIP:
            begin
                skip_left = skip_left - 16'd1;
                if (skip_left == 0)
                    walk_phase = PH_MARK;
            end
            PH_PREC:
                walk_phase = PH_HH;
            PH_HH:
            begin
                sof_height = {16'h0, b, 8'h00};
                walk_phase = PH_HL;
            end
            PH_HL:
            begin
                sof_height[7:0] = b;
                walk_phase      = PH_WH;
            end
            PH_WH:
            begin
                sof_width  = {16'h0, b, 8'h00};
                walk_phase = PH_WL;
            end
            PH_WL:
            begin
                sof_width[7:0] = b;
                sof_seen       = 1'b1;
                walk_phase     = PH_DONE;
            end
            default:
                ;
        endcase

        if (fin)
        begin
            dims = '0;
            dims.status = STAT_UNKNOWN;
            if (byte_count < HEADER_LEN)
                dims.status = STAT_SHORT;
            else
            begin
                jfif_head = header_store[0] == BYTE_FF && header_store[1] == BYTE_SOI &&
                            header_store[2] == BYTE_FF && header_store[3] == BYTE_APP0 &&
                            header_word(5'd6) == JFIF_TAG;
                png_head  = {header_word(5'd0), header_word(5'd4)} == PNG_SIGNATURE &&
                            header_word(5'd12) == IHDR_TAG;
                if (jfif_head)
                begin
                    if (sof_seen)
                    begin
                        dims.width  = sof_width;
                        dims.height = sof_height;
                        dims.format = FMT_JPEG;
                        dims.status = STAT_OK;
                    end
                    else if (walk_phase == PH_BAD)
                        dims.status = STAT_UNKNOWN;
                    else
                        dims.status = STAT_TRUNCATED;
                end
                else if (png_head)
                begin
                    dims.width  = header_word(5'd16);
                    dims.height = header_word(5'd20);
                    dims.format = FMT_PNG;
                    dims.status = STAT_OK;
                end
            end
            dims_expected.push_back(dims);
            clear_parse();
        end
    endtask

    task automatic check_result();
        result_t want;
        if (dims_expected.size() == 0)
            report_mismatch("result with none expected, status", 32'(parse_status), '0);
        else
        begin
            want = dims_expected.pop_front();
            if (image_width !== want.width)
                report_mismatch("image_width", image_width, want.width);
            if (image_height !== want.height)
                report_mismatch("image_height", image_height, want.height);
            if (image_format !== want.format)
                report_mismatch("image_format", 32'(image_format), 32'(want.format));
            if (parse_status !== want.status)
                report_mismatch("parse_status", 32'(parse_status), 32'(want.status));
        end
    endtask

    initial
    begin
        fail_count     = 0;
        pending        = 0;
        leftovers_done = 1'b0;
        clear_parse();
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_parse();
            dims_expected.delete();
            pending = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                absorb_byte(data_byte, last_byte);
            if (out_valid && !out_stall)
                check_result();
            if (end_check && !leftovers_done)
            begin
                leftovers_done = 1'b1;
                if (dims_expected.size() != 0)
                    report_mismatch("results never delivered, count", dims_expected.size(), 0);
            end
            pending = dims_expected.size();
        end
    end

endmodule

// File: dv/tb_top.sv
// Testbench top for the image header dimension parser: clock, reset, file stimulus and verdict.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ihdp_pkg::*;

    localparam logic [7:0] MARK_DHT  = 8'hC4;
    localparam logic [7:0] MARK_SOF5 = 8'hC5;
    localparam logic [7:0] MARK_SOF7 = 8'hC7;
    localparam logic [7:0] MARK_JPG  = 8'hC8;
    localparam logic [7:0] MARK_DAC  = 8'hCC;
    localparam logic [7:0] MARK_DQT  = 8'hDB;
    localparam logic [7:0] MARK_APP1 = 8'hE1;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic [7:0]  data_byte = '0;
    logic        last_byte = 1'b0;
    logic        out_stall = 1'b0;
    logic        end_check = 1'b0;
    wire         in_stall;
    wire         out_valid;
    wire  [31:0] image_width;
    wire  [31:0] image_height;
    wire  [1:0]  image_format;
    wire  [1:0]  parse_status;

    int          fail_count;
    int          pending;
    logic [7:0]  file_bytes [$];
    int          bytes_sent = 0;
    int          hold_len   = 0;
    bit          gaps_on    = 1'b0;
    bit          stall_on   = 1'b0;

    image_header_dimension_parser uut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .data_byte    (data_byte),
        .last_byte    (last_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .image_width  (image_width),
        .image_height (image_height),
        .image_format (image_format),
        .parse_status (parse_status)
    );

    ihdp_result_checker result_chk
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .data_byte    (data_byte),
        .last_byte    (last_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .image_width  (image_width),
        .image_height (image_height),
        .image_format (image_format),
        .parse_status (parse_status),
        .end_check    (end_check),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    always #1 clk = ~clk;

    function automatic int pick_span();
        int r;
        r = $urandom_range(99, 0);
        if (r < 70)
            return $urandom_range(3, 1);
        if (r < 95)
            return $urandom_range(8, 4);
        return $urandom_range(40, 15);
    endfunction

    function automatic logic [7:0] frame_code_at(input int idx);
        case (idx)
            0:       return SOF_C0;
            1:       return SOF_C1;
            2:       return SOF_C2;
            3:       return SOF_C3;
            4:       return SOF_C9;
            5:       return SOF_CA;
            default: return SOF_CB;
        endcase
    endfunction

    function automatic logic is_frame_code(input logic [7:0] c);
        int k;
        for (k = 0; k < 7; k++)
            if (c == frame_code_at(k))
                return 1'b1;
        return 1'b0;
    endfunction

    function automatic logic [7:0] other_code();
        logic [7:0] c;
        case ($urandom_range(9, 0))
            0:       c = MARK_DHT;
            1:       c = MARK_SOF5;
            2:       c = MARK_SOF7;
            3:       c = MARK_JPG;
            4:       c = MARK_DAC;
            5:       c = MARK_DQT;
            6:       c = BYTE_FF;
            default:
            begin
                do
                    c = 8'($urandom_range(255, 0));
                while (is_frame_code(c));
            end
        endcase
        return c;
    endfunction

    function automatic logic [15:0] pick16();
        int r;
        r = $urandom_range(99, 0);
        if (r < 10)
            return '0;
        if (r < 20)
            return '1;
        return 16'($urandom_range(16'hFFFF, 0));
    endfunction

    function automatic logic [31:0] pick32();
        int r;
        r = $urandom_range(99, 0);
        if (r < 10)
            return '0;
        if (r < 20)
            return '1;
        return $urandom();
    endfunction

    function automatic logic [15:0] pick_seg_len();
        int r;
        r = $urandom_range(99, 0);
        if (r < 4)
            return 16'($urandom_range(1, 0));
        if (r < 14)
            return 16'd2;
        if (r < 97)
            return 16'($urandom_range(24, 3));
        return 16'($urandom_range(270, 256));
    endfunction

    task automatic put8(input logic [7:0] b);
        file_bytes.push_back(b);
    endtask

    task automatic put16(input logic [15:0] v);
        put8(v[15:8]);
        put8(v[7:0]);
    endtask

    task automatic put32(input logic [31:0] v);
        put16(v[31:16]);
        put16(v[15:0]);
    endtask

    task automatic put_noise(input int n);
        repeat (n) put8(8'($urandom_range(255, 0)));
    endtask

    task automatic put_png(input logic [31:0] w, input logic [31:0] h);
        put32(PNG_SIGNATURE[63:32]);
        put32(PNG_SIGNATURE[31:0]);
        put32($urandom());
        put32(IHDR_TAG);
        put32(w);
        put32(h);
    endtask

    task automatic put_jfif(input logic [15:0] app_len);
        put8(BYTE_FF);
        put8(BYTE_SOI);
        put8(BYTE_FF);
        put8(BYTE_APP0);
        put16(app_len);
        put32(JFIF_TAG);
        if (app_len > 6)
            put_noise(int'(app_len) - 6);
    endtask

    task automatic put_segment(input logic [7:0] code, input logic [15:0] len);
        put8(BYTE_FF);
        put8(code);
        put16(len);
        if (len > 2)
            put_noise(int'(len) - 2);
    endtask

    task automatic put_frame(input logic [7:0] code, input logic [15:0] h, input logic [15:0] w);
        put8(BYTE_FF);
        put8(code);
        put16(16'd17);
        put8(8'd8);
        put16(h);
        put16(w);
        put_noise($urandom_range(4, 0));
    endtask

    task automatic cut_to(input int keep);
        while (file_bytes.size() > keep)
            void'(file_bytes.pop_back());
    endtask

    task automatic make_random_file();
        int kind;
        int r;
        file_bytes.delete();
        kind = $urandom_range(99, 0);
        if (kind < 40)
        begin
            put_jfif(($urandom_range(9, 0) == 0) ? 16'($urandom_range(30, 2)) : 16'd16);
            repeat ($urandom_range(3, 0)) put_segment(other_code(), pick_seg_len());
            put_frame(frame_code_at($urandom_range(6, 0)), pick16(), pick16());
            put_noise($urandom_range(6, 0));
        end
        else if (kind < 70)
        begin
            put_png(pick32(), pick32());
            put_noise($urandom_range(8, 0));
        end
        else if (kind < 82)
            put_noise($urandom_range(23, 1));
        else
        begin
            if ($urandom_range(1, 0) == 1)
                put_jfif(16'd16);
            put_noise($urandom_range(40, 24));
        end
        r = $urandom_range(99, 0);
        if (r < 12 && file_bytes.size() > 1)
            cut_to($urandom_range(file_bytes.size() - 1, 1));
        else if (r < 22)
            file_bytes[$urandom_range(file_bytes.size() - 1, 0)] = 8'($urandom_range(255, 0));
    endtask

    task automatic send_file();
        int i;
        int gap;
        for (i = 0; i < file_bytes.size(); i++)
        begin
            gap = (gaps_on && $urandom_range(99, 0) >= 55) ? pick_span() : 0;
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            in_valid  <= 1'b1;
            data_byte <= file_bytes[i];
            last_byte <= (i == file_bytes.size() - 1);
            do
                @(posedge clk);
            while (in_stall);
            bytes_sent++;
        end
    endtask

    task automatic drain();
        int n;
        in_valid <= 1'b0;
        n = 0;
        do
        begin
            @(posedge clk);
            n++;
        end
        while ((pending != 0 || n < 4) && n < 5000);
    endtask

    initial
    begin : receiver
        int  run_left;
        int  hold_left;
        bit  run_stall;
        run_left  = 0;
        hold_left = 0;
        run_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_len > 0)
            begin
                hold_left = hold_len;
                hold_len  = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (!stall_on)
                out_stall <= 1'b0;
            else
            begin
                if (run_left == 0)
                begin
                    run_stall = ($urandom_range(99, 0) < 40);
                    run_left  = pick_span();
                end
                run_left--;
                out_stall <= run_stall;
            end
        end
    end

    initial
    begin : stimulus
        int i;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        file_bytes.delete();
        put8(8'h00);
        send_file();
        file_bytes.delete();
        repeat (23) put8(8'hFF);
        send_file();
        file_bytes.delete();
        put_png('1, '0);
        send_file();
        file_bytes.delete();
        put_png('0, '1);
        put_noise(5);
        send_file();
        file_bytes.delete();
        put_png(32'd640, 32'd480);
        file_bytes[0] = 8'h88;
        send_file();
        file_bytes.delete();
        put_png(32'd640, 32'd480);
        file_bytes[15] = 8'h53;
        send_file();
        file_bytes.delete();
        repeat (24) put8(8'h00);
        send_file();
        for (i = 0; i < 7; i++)
        begin
            file_bytes.delete();
            put_jfif(16'd16);
            put_frame(frame_code_at(i), (i == 0) ? 16'hFFFF : pick16(),
                      (i == 0) ? 16'h0000 : pick16());
            send_file();
        end
        file_bytes.delete();
        put_jfif(16'd16);
        put_segment(MARK_DQT, 16'd5);
        put_segment(BYTE_FF, 16'd4);
        put_segment(MARK_DHT, 16'd2);
        put_frame(SOF_C1, 16'd1080, 16'd1920);
        put_noise(12);
        send_file();
        file_bytes.delete();
        put_jfif(16'd16);
        put_segment(MARK_DQT, 16'd1);
        put_noise(8);
        send_file();
        file_bytes.delete();
        put_jfif(16'd16);
        put_segment(MARK_DHT, 16'd0);
        put_noise(8);
        send_file();
        file_bytes.delete();
        put_jfif(16'd16);
        put8(8'h00);
        put_noise(8);
        send_file();
        file_bytes.delete();
        put_jfif(16'd16);
        put_frame(SOF_C2, 16'h1234, 16'h5678);
        cut_to(28);
        send_file();
        file_bytes.delete();
        put_jfif(16'd16);
        put_segment(MARK_SOF5, 16'd4);
        put_segment(MARK_DAC, 16'd3);
        put_segment(MARK_JPG, 16'd6);
        send_file();
        file_bytes.delete();
        put_jfif(16'd16);
        file_bytes[3] = MARK_APP1;
        put_frame(SOF_C0, 16'd100, 16'd200);
        send_file();
        file_bytes.delete();
        put_jfif(16'd16);
        file_bytes[8] = 8'h58;
        put_frame(SOF_C0, 16'd100, 16'd200);
        send_file();
        file_bytes.delete();
        put_jfif(16'd6);
        put_frame(SOF_C3, 16'd7, 16'd9);
        cut_to(19);
        send_file();
        drain();

        hold_len = 80;
        for (i = 0; i < 30; i++)
        begin
            file_bytes.delete();
            put8(8'($urandom_range(255, 0)));
            send_file();
        end
        drain();

        gaps_on  = 1'b1;
        stall_on = 1'b1;
        while (bytes_sent < 1100)
        begin
            if ($urandom_range(99, 0) < 8)
                gaps_on = !gaps_on;
            if ($urandom_range(99, 0) < 8)
                stall_on = !stall_on;
            make_random_file();
            send_file();
            if ($urandom_range(99, 0) < 4)
                drain();
        end
        drain();

        end_check <= 1'b1;
        repeat (2) @(posedge clk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin : watchdog
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
